@@ rtl/core/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_CLOSE  = 2'd1,
    EV_REJECT = 2'd2,
    EV_EMPTY  = 2'd3
  } wsd_event_e;

  localparam logic [7:0] OpText   = 8'h81;
  localparam logic [7:0] OpBinary = 8'h82;
  localparam logic [7:0] OpClose  = 8'h88;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;
  localparam logic [15:0] MaxPayloadReset = 16'd4096;

  typedef struct packed {
    wsd_event_e  kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic        binary;
    logic [15:0] length;
  } wsd_cmd_t;

endpackage

@@ rtl/core/wsd_if.sv @@
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels of the frame deframer.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;
  modport source (output valid, output rx_byte, output buffer_start, input ready);
  modport sink (input valid, input rx_byte, input buffer_start, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        binary_frame;
  logic [15:0] frame_length;
  modport source (output valid, output event_kind, output payload_byte,
                  output last_byte, output binary_frame, output frame_length,
                  input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input last_byte, input binary_frame, input frame_length,
                output ready);
endinterface

interface wsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload;
  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface

@@ rtl/core/wsd_front.sv @@
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: tracks the frame phase and queues one command per result.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              buffer_start_i,
  input  logic [15:0]       max_payload_i,
  output logic              push_o,
  output wsd_pkg::wsd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hc_q, hc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [31:0] key_q, key_d;
  logic        mask_q, mask_d;
  logic        bin_q, bin_d;

  logic        lk_go;
  logic [15:0] lk_len;
  logic        lk_mask;
  logic [7:0]  key_byte;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    len_d   = len_q;
    idx_d   = idx_q;
    key_d   = key_q;
    mask_d  = mask_q;
    bin_d   = bin_q;
    lk_go   = 1'b0;
    lk_len  = len_q;
    lk_mask = mask_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (fire_i) begin
      if (buffer_start_i) begin
        hc_d   = '0;
        len_d  = '0;
        idx_d  = '0;
        key_d  = '0;
        mask_d = 1'b0;
        bin_d  = 1'b0;
        if (rx_byte_i == wsd_pkg::OpClose) begin
          phase_d    = PH_IDLE;
          push_o     = 1'b1;
          cmd_o.kind = wsd_pkg::EV_CLOSE;
        end else if (rx_byte_i == wsd_pkg::OpText || rx_byte_i == wsd_pkg::OpBinary) begin
          bin_d   = (rx_byte_i == wsd_pkg::OpBinary);
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_LEN: begin
            mask_d = rx_byte_i[7];
            if (rx_byte_i[6:0] == wsd_pkg::LenExt64) begin
              phase_d      = PH_IDLE;
              push_o       = 1'b1;
              cmd_o.kind   = wsd_pkg::EV_REJECT;
              cmd_o.binary = bin_q;
            end else if (rx_byte_i[6:0] == wsd_pkg::LenExt16) begin
              phase_d = PH_EXT;
              hc_d    = '0;
              len_d   = '0;
            end else begin
              len_d   = {9'd0, rx_byte_i[6:0]};
              lk_go   = 1'b1;
              lk_len  = len_d;
              lk_mask = rx_byte_i[7];
            end
          end
          PH_EXT: begin
            len_d  = {len_q[7:0], rx_byte_i};
            hc_d   = hc_q + 3'd1;
            lk_go  = (hc_d >= 3'd2);
            lk_len = len_d;
          end
          PH_MASK: begin
            key_d = {key_q[23:0], rx_byte_i};
            hc_d  = hc_q + 3'd1;
            if (hc_d >= 3'd4) begin
              idx_d = '0;
              if (len_q == 16'd0) begin
                phase_d      = PH_IDLE;
                push_o       = 1'b1;
                cmd_o.kind   = wsd_pkg::EV_EMPTY;
                cmd_o.binary = bin_q;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            idx_d        = idx_q + 16'd1;
            push_o       = 1'b1;
            cmd_o.kind   = wsd_pkg::EV_DATA;
            cmd_o.data   = rx_byte_i;
            cmd_o.key    = mask_q ? key_byte : 8'd0;
            cmd_o.last   = (idx_d >= len_q);
            cmd_o.binary = bin_q;
            cmd_o.length = len_q;
            if (idx_d >= len_q) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        if (lk_go) begin
          if (lk_len > max_payload_i) begin
            phase_d      = PH_IDLE;
            push_o       = 1'b1;
            cmd_o.kind   = wsd_pkg::EV_REJECT;
            cmd_o.binary = bin_q;
            cmd_o.length = lk_len;
          end else if (lk_mask) begin
            phase_d = PH_MASK;
            hc_d    = '0;
          end else if (lk_len == 16'd0) begin
            phase_d      = PH_IDLE;
            push_o       = 1'b1;
            cmd_o.kind   = wsd_pkg::EV_EMPTY;
            cmd_o.binary = bin_q;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      key_q   <= '0;
      mask_q  <= 1'b0;
      bin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      key_q   <= key_d;
      mask_q  <= mask_d;
      bin_q   <= bin_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_data_from_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.kind == wsd_pkg::EV_DATA |-> phase_q == PH_PAYLOAD && !buffer_start_i)
    else $error("payload beat queued outside the payload phase");
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> len_q != 16'd0 && idx_q < len_q)
    else $error("payload phase with no bytes left");
`endif

endmodule

@@ rtl/core/wsd_fifo.sv @@
// ----------------------------------------------------------------------------
// wsd_fifo
// Short command queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsd_pkg::wsd_cmd_t wdata_i,
  input  logic              pop_i,
  output wsd_pkg::wsd_cmd_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  wsd_pkg::wsd_cmd_t mem_q [Depth];
  logic [AddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

@@ rtl/core/wsd_back.sv @@
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks payload and holds the result beat until taken.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  wsd_pkg::wsd_cmd_t cmd_i,
  output logic              pop_o,
  wsd_out_if.source         out_o
);

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        bin_q;
  logic [15:0] len_q;

  assign pop_o = cmd_valid_i && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= cmd_i.kind;
      byte_q <= cmd_i.data ^ cmd_i.key;
      last_q <= cmd_i.last;
      bin_q  <= cmd_i.binary;
      len_q  <= cmd_i.length;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.event_kind   = kind_q;
  assign out_o.payload_byte = byte_q;
  assign out_o.last_byte    = last_q;
  assign out_o.binary_frame = bin_q;
  assign out_o.frame_length = len_q;

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Path: a result beat is written into the command queue, then registered in the output stage.
// Throughput: one received byte per cycle; the input stalls only while the
// two-entry command queue between the header parser and the output is full.
// Reset: asynchronous and active low; the parser returns to idle, the queue
// and output empty, and the payload limit to 4096.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_in_if.sink    in_i,
  wsd_cfg_if.sink   cfg_i,
  wsd_out_if.source out_o
);

  logic [15:0]       max_payload_q;
  logic              fire, push, pop, full, empty;
  wsd_pkg::wsd_cmd_t cmd_w, cmd_r;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full;
  assign fire        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= wsd_pkg::MaxPayloadReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      max_payload_q <= cfg_i.max_payload;
    end
  end

  wsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .rx_byte_i      (in_i.rx_byte),
    .buffer_start_i (in_i.buffer_start),
    .max_payload_i  (max_payload_q),
    .push_o         (push),
    .cmd_o          (cmd_w)
  );

  wsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_w),
    .pop_i   (pop),
    .rdata_o (cmd_r),
    .full_o  (full),
    .empty_o (empty)
  );

  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (cmd_r),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
